// ===== rtl/diff_drive_odometry_integrator_macros.svh =====
// Assertion macros shared by the odometry integrator RTL.
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DDOI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ddoi: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define DDOI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ddoi: next-cycle check failed");

`endif

// ===== rtl/ddoi_pkg.sv =====
package ddoi_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ITER_W       = 5;

    typedef logic [ITER_W-1:0] t_iter;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POS,
        ST_QUAT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [33:0] angle;
    } t_cordic_ctl;

    typedef struct packed {
        logic  busy;
        logic  last;
        t_iter iter;
    } t_cordic_sts;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic [15:0]        RADIUS_RST  = 16'd3329;

    // atan(2^-i) in Q30, rounded down
    function automatic logic [29:0] atan_q30(input t_iter idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
        logic signed [39:0] r;
        if (v[40] != v[39]) begin
            r = v[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

    // Q30 to Q1.15 with round half up and saturation
    function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [17:0] q;
        logic signed [15:0] r;
        t = {v[31], v} + 33'sd16384;
        q = t[32:15];
        if (q > 18'sd32767) begin
            r = 16'sd32767;
        end else if (q < -18'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ddoi_cordic.sv =====
module ddoi_cordic #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ddoi_pkg::t_cordic_ctl     i_ctl,
    output ddoi_pkg::t_cordic_sts     o_sts,
    output logic signed [31:0]        o_cos,
    output logic signed [31:0]        o_sin
);

    localparam int CW = $clog2(TRIG_ITERATIONS);

    logic                r_busy;
    logic [CW-1:0]       r_cnt;
    logic signed [31:0]  r_x, r_y, r_cos, r_sin;
    logic signed [33:0]  r_z;
    logic                r_neg;

    logic signed [31:0]  n_x, n_y;
    logic signed [33:0]  n_z;
    logic signed [33:0]  w_atan;
    logic signed [33:0]  w_red;
    logic                w_red_neg;
    logic                w_last;

    assign w_last = r_busy && (r_cnt == CW'(TRIG_ITERATIONS - 1));
    assign w_atan = {4'b0000, ddoi_pkg::atan_q30(ddoi_pkg::t_iter'(r_cnt))};

    // fold the angle into plus or minus pi/2, negate the results later
    always_comb begin
        w_red     = i_ctl.angle;
        w_red_neg = 1'b0;
        if (i_ctl.angle > ddoi_pkg::HALF_PI_Q30) begin
            w_red     = i_ctl.angle - ddoi_pkg::PI_Q30;
            w_red_neg = 1'b1;
        end else if (i_ctl.angle < -ddoi_pkg::HALF_PI_Q30) begin
            w_red     = i_ctl.angle + ddoi_pkg::PI_Q30;
            w_red_neg = 1'b1;
        end
    end

    always_comb begin
        if (!r_z[33]) begin
            n_x = r_x - (r_y >>> r_cnt);
            n_y = r_y + (r_x >>> r_cnt);
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + (r_y >>> r_cnt);
            n_y = r_y - (r_x >>> r_cnt);
            n_z = r_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= !w_last;
            r_cnt  <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= ddoi_pkg::GAIN_Q30;
            r_y   <= '0;
            r_z   <= w_red;
            r_neg <= w_red_neg;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        // capture the finished rotation even when the next one starts
        if (w_last) begin
            r_cos <= r_neg ? -n_x : n_x;
            r_sin <= r_neg ? -n_y : n_y;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.last = w_last;
    assign o_sts.iter = ddoi_pkg::t_iter'(r_cnt);
    assign o_cos      = r_cos;
    assign o_sin      = r_sin;

endmodule

// ===== rtl/diff_drive_odometry_integrator.sv =====
// Differential drive odometry integrator.
// Input words on s_axis carry the left and right wheel angles and the yaw;
// each accepted word yields exactly one result word on m_axis with the
// saturating pose x and y and the half-yaw quaternion parts z and w.
// The wheel radius is written on the cfg channel, by the user only while the
// block idles, which the block does not enforce; o_cfg_ready is always high.
// One shared CORDIC shift-add unit runs TRIG_ITERATIONS steps for the yaw
// and then again for the half yaw; a new word is accepted only once the
// previous result has gone to the output register. The single shared
// multiplier works beside the CORDIC. s_axis_tready is high only while no
// word is in flight.
// The result sits in an output register: a stalled receiver does not stop the
// next word being accepted; only a second finished result waits for the slot.
// Reset (synchronous, active low) clears the pose, forgets the previous wheel
// angles so that the next word only seeds them, and sets the radius to 3329.
module diff_drive_odometry_integrator #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // left_wheel_angle[31:0], right_wheel_angle[63:32], heading[82:64], zero pad
    input  logic [87:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // pos_x[39:0], pos_y[79:40], quat_z[95:80], quat_w[111:96]
    output logic [111:0]  m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data
);

    ddoi_pkg::t_state      r_state, n_state;
    ddoi_pkg::t_cordic_ctl w_ctl;
    ddoi_pkg::t_cordic_sts w_sts;
    logic signed [31:0]    w_cos, w_sin;

    logic [15:0]           r_radius;
    logic                  r_seeded;
    logic [31:0]           r_prev_l, r_prev_r;
    logic signed [39:0]    r_acc_x, r_acc_y;
    logic signed [32:0]    r_dsum, r_ds;
    logic signed [18:0]    r_head;
    logic signed [63:0]    r_prod;
    logic                  r_out_valid;
    logic [111:0]          r_out_data;

    logic                  w_in_acc, w_load;
    logic [31:0]           w_left, w_right, w_dl, w_dr;
    logic signed [18:0]    w_head;
    logic signed [33:0]    w_head_ext;
    logic signed [32:0]    w_dsum;
    logic signed [32:0]    w_mul_a, w_mul_b;
    logic signed [65:0]    w_mul_p;
    logic signed [63:0]    w_ds_rnd, w_d_rnd;
    logic signed [40:0]    w_sum_x, w_sum_y;

    assign w_left  = s_axis_tdata[31:0];
    assign w_right = s_axis_tdata[63:32];
    assign w_head  = s_axis_tdata[82:64];

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // the first word seeds the previous angles, so its changes are zero
    assign w_dl   = w_left - (r_seeded ? r_prev_l : w_left);
    assign w_dr   = w_right - (r_seeded ? r_prev_r : w_right);
    assign w_dsum = {w_dl[31], w_dl} + {w_dr[31], w_dr};

    assign w_head_ext = w_in_acc ? {{15{w_head[18]}}, w_head} : {{15{r_head[18]}}, r_head};

    // shared multiplier: distance scale, then distance times cos and sin
    always_comb begin
        w_mul_a = r_ds;
        w_mul_b = {w_cos[31], w_cos};
        if (r_state == ddoi_pkg::ST_POS) begin
            w_mul_a = r_dsum;
            w_mul_b = {17'd0, r_radius};
        end else if (w_sts.iter != ddoi_pkg::t_iter'(0)) begin
            w_mul_b = {w_sin[31], w_sin};
        end
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_ds_rnd = (r_prod + 64'sd65536) >>> 17;
    assign w_d_rnd  = (r_prod + 64'sd536870912) >>> 30;
    assign w_sum_x  = {r_acc_x[39], r_acc_x} + w_d_rnd[40:0];
    assign w_sum_y  = {r_acc_y[39], r_acc_y} + w_d_rnd[40:0];

    always_comb begin
        n_state     = r_state;
        w_ctl.start = 1'b0;
        w_ctl.angle = w_head_ext <<< 14;
        w_load      = 1'b0;
        case (r_state)
            ddoi_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    w_ctl.start = 1'b1;
                    n_state     = ddoi_pkg::ST_POS;
                end
            end
            ddoi_pkg::ST_POS: begin
                // chain the half-yaw rotation straight after the yaw rotation
                w_ctl.angle = w_head_ext <<< 13;
                if (w_sts.last) begin
                    w_ctl.start = 1'b1;
                    n_state     = ddoi_pkg::ST_QUAT;
                end
            end
            ddoi_pkg::ST_QUAT: begin
                if (w_sts.last) begin
                    n_state = ddoi_pkg::ST_OUT;
                end
            end
            ddoi_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = ddoi_pkg::ST_IDLE;
                end
            end
            default: n_state = ddoi_pkg::ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ddoi_pkg::ST_IDLE);

    ddoi_cordic #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ddoi_pkg::ST_IDLE;
            r_radius    <= ddoi_pkg::RADIUS_RST;
            r_seeded    <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_seeded <= 1'b1;
            end
            if (r_state == ddoi_pkg::ST_QUAT && w_sts.iter == ddoi_pkg::t_iter'(1)) begin
                r_acc_x <= ddoi_pkg::sat40(w_sum_x);
            end
            if (r_state == ddoi_pkg::ST_QUAT && w_sts.iter == ddoi_pkg::t_iter'(2)) begin
                r_acc_y <= ddoi_pkg::sat40(w_sum_y);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_prev_l <= w_left;
            r_prev_r <= w_right;
            r_dsum   <= w_dsum;
            r_head   <= w_head;
        end
        if (r_state == ddoi_pkg::ST_POS || r_state == ddoi_pkg::ST_QUAT) begin
            r_prod <= w_mul_p[63:0];
        end
        if (r_state == ddoi_pkg::ST_POS && w_sts.iter == ddoi_pkg::t_iter'(1)) begin
            r_ds <= w_ds_rnd[32:0];
        end
        if (w_load) begin
            r_out_data <= {ddoi_pkg::to_q15(w_cos), ddoi_pkg::to_q15(w_sin),
                           r_acc_y, r_acc_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`include "diff_drive_odometry_integrator_macros.svh"

    `DDOI_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_state == ddoi_pkg::ST_POS)
    `DDOI_ASSERT_SAME(a_cordic_busy, i_clk, i_rst_n, r_state == ddoi_pkg::ST_POS || r_state == ddoi_pkg::ST_QUAT, w_sts.busy)
    `DDOI_ASSERT_NEXT(a_out_waits, i_clk, i_rst_n, r_state == ddoi_pkg::ST_OUT && r_out_valid && !m_axis_tready, r_state == ddoi_pkg::ST_OUT)

endmodule

// ===== test/tb_diff_drive_odometry_integrator.sv =====
`timescale 1ns / 1ps

module tb_diff_drive_odometry_integrator;

    localparam int TRIG_STEPS     = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint POS_TOP     = 64'sd549755813887;
    localparam longint POS_BOTTOM  = -64'sd549755813888;

    // yaw in Q2.16
    localparam logic [18:0] YAW_PI      = 19'd205887;
    localparam logic [18:0] YAW_HALF_PI = 19'd102943;
    localparam logic [18:0] YAW_TOP     = 19'h3FFFF;
    localparam logic [18:0] YAW_BOTTOM  = 19'h40000;

    typedef struct packed {
        logic signed [18:0] heading;
        logic [31:0]        right;
        logic [31:0]        left;
    } odo_sample_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_z;
        logic signed [39:0] pos_y;
        logic signed [39:0] pos_x;
    } pose_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [87:0]   s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [111:0]  m_axis_tdata;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [15:0]   i_cfg_data = '0;

    diff_drive_odometry_integrator #(
        .TRIG_ITERATIONS(TRIG_STEPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // atan(2^-i) in Q30, rounded down
    longint atan_lut [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
    };

    // odometry state as the block should hold it
    logic [15:0] radius_cfg = 16'd3329;
    logic [31:0] odo_prev_left = '0;
    logic [31:0] odo_prev_right = '0;
    longint      odo_x = 0;
    longint      odo_y = 0;
    logic        odo_seeded = 1'b0;

    odo_sample_t pending_samples [$];
    pose_t       pose_expected [$];
    int          words_offered = 0;
    int          words_taken = 0;
    int          mismatches = 0;

    logic [31:0] gen_left = '0;
    logic [31:0] gen_right = '0;
    logic        sender_idles = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;

    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0]  pattern_pos = '0;
    int          holds_requested = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    function automatic void cordic_rotate(input longint angle, output longint cos_v,
                                          output longint sin_v);
        longint x, y, z, nx;
        logic   flip;
        int     i;
        x = GAIN_Q30;
        y = 0;
        z = angle;
        flip = 1'b0;
        // fold into the right half plane, negate afterwards
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            flip = 1'b1;
        end
        for (i = 0; i < TRIG_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_lut[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_lut[i];
            end
            x = nx;
        end
        cos_v = flip ? -x : x;
        sin_v = flip ? -y : y;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_TOP) return POS_TOP;
        if (v < POS_BOTTOM) return POS_BOTTOM;
        return v;
    endfunction

    function automatic logic signed [15:0] round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) return 16'sh7FFF;
        if (r < -32768) return 16'sh8000;
        return 16'(r);
    endfunction

    function automatic pose_t advance_pose(input odo_sample_t smp);
        logic [31:0] dl, dr;
        longint      dsum, ds, c, sn, hc, hs;
        pose_t       p;
        // first word after reset only seeds the wheel angles
        if (!odo_seeded) begin
            odo_prev_left = smp.left;
            odo_prev_right = smp.right;
            odo_seeded = 1'b1;
        end
        dl = smp.left - odo_prev_left;
        dr = smp.right - odo_prev_right;
        odo_prev_left = smp.left;
        odo_prev_right = smp.right;
        dsum = longint'($signed(dl)) + longint'($signed(dr));
        ds = (dsum * longint'(radius_cfg) + 65536) >>> 17;
        cordic_rotate(longint'(smp.heading) * 16384, c, sn);
        odo_x = clamp_pos(odo_x + ((ds * c + 536870912) >>> 30));
        odo_y = clamp_pos(odo_y + ((ds * sn + 536870912) >>> 30));
        cordic_rotate(longint'(smp.heading) * 8192, hc, hs);
        p.pos_x = 40'(odo_x);
        p.pos_y = 40'(odo_y);
        p.quat_z = round_q15(hs);
        p.quat_w = round_q15(hc);
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [39:0] want,
                                        input logic [39:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sender: bursts of words, with random gaps while sender_idles is set
    always @(negedge i_clk) begin
        if (i_rst_n && words_taken == words_offered) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_axis_tdata  <= {5'b0, pending_samples.pop_front()};
                s_axis_tvalid <= 1'b1;
                words_offered++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    if (sender_idles && $urandom_range(0, 2) != 0) begin
                        gap_left = $urandom_range(1, 45);
                    end else begin
                        gap_left = 0;
                    end
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotating ready pattern, or a long hold on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ready_pattern[pattern_pos];
            pattern_pos++;
        end
    end

    // predict on every accepted word, check every result word
    always @(posedge i_clk) begin
        pose_t got, want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pose_expected.push_back(advance_pose(odo_sample_t'(s_axis_tdata[82:0])));
                words_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = pose_t'(m_axis_tdata);
                if (pose_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pose_expected.pop_front();
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("quat_z", 40'(want.quat_z), 40'(got.quat_z));
                    check_field("quat_w", 40'(want.quat_w), 40'(got.quat_w));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                radius_cfg = i_cfg_data;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_sample(input logic [31:0] left, input logic [31:0] right,
                               input logic [18:0] heading);
        odo_sample_t smp;
        smp.left = left;
        smp.right = right;
        smp.heading = heading;
        gen_left = left;
        gen_right = right;
        pending_samples.push_back(smp);
    endtask

    // wheels walk by deltas of every size; now and then a jump or a wild yaw
    task automatic push_random_sample();
        logic [31:0] dl, dr;
        logic [18:0] hd;
        int          mode;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 6) == 0) begin
            hd = 19'($urandom);
        end else begin
            hd = 19'(int'($urandom_range(0, 411774)) - 205887);
        end
        dl = 32'($signed($urandom) >>> $urandom_range(0, 31));
        if (mode < 4) begin
            dr = dl + 32'($signed($urandom) >>> $urandom_range(8, 31));
        end else begin
            dr = 32'($signed($urandom) >>> $urandom_range(0, 31));
        end
        if (mode == 9) begin
            push_sample($urandom, $urandom, hd);
        end else begin
            push_sample(gen_left + dl, gen_right + dr, hd);
        end
    endtask

    // full-speed drive on a near-constant yaw, to push the pose into saturation
    task automatic push_drive_run(input int count, input int aim);
        repeat (count) begin
            push_sample(gen_left + 32'h7FFF_0000 + 32'($urandom_range(0, 16'hFFFF)),
                        gen_right + 32'h7FFF_0000 + 32'($urandom_range(0, 16'hFFFF)),
                        19'(aim + int'($urandom_range(0, 6000)) - 3000));
        end
    endtask

    task automatic write_radius(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || words_taken != words_offered ||
               pose_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset radius, no idling: seeding, wrap, extreme deltas and yaw corners
        push_sample(32'h1234_5678, 32'h9ABC_DEF0, '0);
        push_sample(gen_left + 32'h0010_0000, gen_right + 32'h0010_0000, 19'd51472);
        push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, YAW_PI);
        push_sample(32'h8000_0000, 32'h8000_0000, -YAW_PI);
        push_sample(32'h0000_0000, 32'h0000_0000, YAW_TOP);
        push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, YAW_BOTTOM);
        push_sample(gen_left, gen_right, YAW_HALF_PI);
        push_sample(gen_left + 32'd5000, gen_right - 32'd5000, YAW_HALF_PI + 19'd1);
        push_sample(gen_left + 32'd70000, gen_right + 32'd90000, -YAW_HALF_PI);
        push_sample(gen_left - 32'd70000, gen_right - 32'd90000, -YAW_HALF_PI - 19'd1);
        push_sample(32'hFFFF_FFFF, 32'h0000_0000, 19'd1);
        push_sample(gen_left, 32'hFFFF_FFFF, 19'h7FFFF);
        push_sample(gen_left + 32'h4000_0000, gen_right, YAW_PI + 19'd1);
        push_sample(gen_left, gen_right + 32'hC000_0000, -YAW_PI - 19'd1);
        push_sample(gen_left + 32'h7FFF_FFFF, gen_right + 32'h7FFF_FFFF, '0);
        push_sample(gen_left + 32'h8000_0000, gen_right + 32'h8000_0000, '0);
        wait_drained();

        // largest radius; receiver holds off long while words keep coming
        write_radius(16'hFFFF);
        sender_idles = 1'b1;
        ready_pattern = 16'($urandom) | 16'h0101;
        holds_requested++;
        repeat (60) push_random_sample();
        wait_drained();

        write_radius(16'h0000);
        ready_pattern = 16'($urandom) | 16'h1000;
        repeat (30) push_random_sample();
        wait_drained();

        write_radius(16'($urandom));
        sender_idles = 1'b0;
        ready_pattern = 16'hFFFF;
        repeat (25) push_random_sample();
        wait_drained();
        sender_idles = 1'b1;
        ready_pattern = 16'($urandom) | 16'h0010;
        repeat (25) push_random_sample();
        wait_drained();

        // drive on a diagonal: x to its top and y to its bottom together
        write_radius(16'hFFFF);
        ready_pattern = 16'($urandom) | 16'h8421;
        push_drive_run(380, -51472);
        repeat (10) push_random_sample();
        wait_drained();

        write_radius(16'h0001);
        repeat (10) push_random_sample();
        wait_drained();

        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pose_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ddoi_pkg.sv
rtl/ddoi_cordic.sv
rtl/diff_drive_odometry_integrator.sv
test/tb_diff_drive_odometry_integrator.sv
